// File: rtl/core/tga_rle_pixel_decoder_unit_macros.svh
// Assertion macros shared by the Targa run-length decoder RTL.
`ifndef TGA_RLE_PIXEL_DECODER_UNIT_MACROS_SVH
`define TGA_RLE_PIXEL_DECODER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on the rising clock edge, muted while in reset.
`define TRLE_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tga rle decoder: same-cycle check failed");
// Next-cycle implication, sampled on the rising clock edge, muted while in reset.
`define TRLE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tga rle decoder: next-cycle check failed");
`else
`define TRLE_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define TRLE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/core/trle_pkg.sv
// Types, register indexes and the pixel conversion of the Targa run-length decoder.
`timescale 1ns / 1ps
`default_nettype none
package trle_pkg;

  // Configuration register indexes.
  localparam logic [1:0] CFG_SOURCE_BYTES   = 2'd0;
  localparam logic [1:0] CFG_OUT_COMPONENTS = 2'd1;
  localparam logic [1:0] CFG_RLE_ENABLE     = 2'd2;

  // Supported pixel sizes and layouts.
  localparam logic [2:0] SZ_1 = 3'd1;
  localparam logic [2:0] SZ_2 = 3'd2;
  localparam logic [2:0] SZ_3 = 3'd3;
  localparam logic [2:0] SZ_4 = 3'd4;

  typedef struct packed {
    logic       format_error;
    logic [7:0] chan3;
    logic [7:0] chan2;
    logic [7:0] chan1;
    logic [7:0] chan0;
  } pix_t;

  typedef struct packed {
    logic       format_error;
    logic [7:0] repeat_count;
    logic [7:0] chan3;
    logic [7:0] chan2;
    logic [7:0] chan1;
    logic [7:0] chan0;
  } res_t;

  // Converts a gathered pixel (byte i at bits 8i+7:8i) to the output layout.
  function automatic pix_t convert_pixel(logic [31:0] st, logic [2:0] s, logic [2:0] d);
    pix_t       p;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
    p  = '0;
    b0 = st[7:0];
    b1 = st[15:8];
    b2 = st[23:16];
    b3 = st[31:24];
    if (s == SZ_2 && (d == SZ_3 || d == SZ_4)) begin
      // 5-5-5 word, low byte first; top bit is the alpha flag.
      p.chan0 = {b1[6:2], 3'b000};
      p.chan1 = {b1[1:0], b0[7:5], 3'b000};
      p.chan2 = {b0[4:0], 3'b000};
      if (d == SZ_4) begin
        p.chan3 = {8{b1[7]}};
      end
    end else if (s == SZ_3 && d == SZ_3) begin
      p.chan0 = b2;
      p.chan1 = b1;
      p.chan2 = b0;
    end else if (s == SZ_4 && (d == SZ_3 || d == SZ_4)) begin
      p.chan0 = b2;
      p.chan1 = b1;
      p.chan2 = b0;
      if (d == SZ_4) begin
        p.chan3 = b3;
      end
    end else if (d == SZ_1 && (s == SZ_1 || s == SZ_2)) begin
      p.chan0 = b0;
    end else if (d == SZ_2 && s == SZ_2) begin
      p.chan0 = b0;
      p.chan1 = b1;
    end else begin
      p.format_error = 1'b1;
    end
    return p;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/tga_rle_pixel_decoder_unit.sv
// Top level of the Targa run-length pixel decoder: byte intake, packet state, output stage.
`timescale 1ns / 1ps
`default_nettype none
`include "tga_rle_pixel_decoder_unit_macros.svh"

// The decoder takes the pixel data of a Targa image as a stream of bytes, one beat per
// byte, and takes a new beat on every clock cycle while in_tready is high. With
// rle_enable set, a byte that arrives while no packet is open is a packet header and
// yields nothing; the following bytes are gathered into stored pixels of source_bytes
// bytes each. Every finished pixel is converted to the layout chosen by out_components
// and leaves as one output beat, registered in the result register or, while that is
// held, in the skid register. A run packet gives a single beat carrying its whole
// repeat count, a literal or raw pixel a beat with count one. Unsupported size and
// layout pairs still give a beat, with all channels zero and format_error set. Setting
// tuser on an input beat starts a new image: packet and pixel state are cleared before
// that byte is taken. The output side has a result register backed by one skid
// register, so in_tready only drops after two results are waiting. Configuration writes
// are accepted on every cycle and should only be made while the decoder is idle; they do
// not clear the packet or pixel state.
module tga_rle_pixel_decoder_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input stream.
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  input  wire logic [0:0]  in_tuser,   // [0] image_start
  // Output stream.
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  output      logic [39:0] out_tdata,  // [7:0] chan0, [15:8] chan1, [23:16] chan2,
                                       // [31:24] chan3, [39:32] repeat_count
  output      logic [0:0]  out_tuser,  // [0] format_error
  // Configuration writes.
  input  wire logic        cfg_valid,
  output      logic        cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [2:0]  cfg_data
);

  // Configuration registers.
  logic [2:0]  src_bytes_r;
  logic [2:0]  out_comp_r;
  logic        rle_en_r;

  // Packet and pixel state.
  logic [7:0]  packet_left_r, packet_left_nxt;
  logic        packet_run_r, packet_run_nxt;
  logic [1:0]  byte_pos_r, byte_pos_nxt;
  logic [31:0] pix_store_r, pix_store_nxt;

  // Output stage: result register and skid register.
  logic        out_v_r;
  trle_pkg::res_t out_res_r;
  logic        skid_v_r;
  trle_pkg::res_t skid_res_r;

  logic        in_acc;
  logic        out_pop;
  logic        start;
  logic [7:0]  left_eff;
  logic        run_eff;
  logic [1:0]  pos_eff;
  logic [31:0] store_eff;
  logic [31:0] store_ins;
  logic        is_header;
  logic [2:0]  pix_size;
  logic        pix_done;
  logic        produce;
  logic [7:0]  count;
  trle_pkg::pix_t conv;
  trle_pkg::res_t res;

  assign cfg_ready = 1'b1;
  assign in_tready = !skid_v_r;
  assign in_acc    = in_tvalid && in_tready;
  assign out_pop   = out_v_r && out_tready;
  assign start     = in_tuser[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_bytes_r <= trle_pkg::SZ_3;
      out_comp_r  <= trle_pkg::SZ_3;
      rle_en_r    <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        trle_pkg::CFG_SOURCE_BYTES:   src_bytes_r <= cfg_data;
        trle_pkg::CFG_OUT_COMPONENTS: out_comp_r  <= cfg_data;
        trle_pkg::CFG_RLE_ENABLE:     rle_en_r    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // A start-of-image beat sees cleared state.
  always_comb begin
    left_eff  = start ? 8'd0  : packet_left_r;
    run_eff   = start ? 1'b0  : packet_run_r;
    pos_eff   = start ? 2'd0  : byte_pos_r;
    store_eff = start ? 32'd0 : pix_store_r;
  end

  // Drop the byte into its lane of the pixel store.
  always_comb begin
    store_ins = store_eff;
    unique case (pos_eff)
      2'd0:    store_ins[7:0]   = in_tdata;
      2'd1:    store_ins[15:8]  = in_tdata;
      2'd2:    store_ins[23:16] = in_tdata;
      default: store_ins[31:24] = in_tdata;
    endcase
  end

  // Gathering size: zero counts as one byte, values above four as four.
  always_comb begin
    if (src_bytes_r == 3'd0) begin
      pix_size = trle_pkg::SZ_1;
    end else if (src_bytes_r > trle_pkg::SZ_4) begin
      pix_size = trle_pkg::SZ_4;
    end else begin
      pix_size = src_bytes_r;
    end
  end

  assign is_header = rle_en_r && (left_eff == 8'd0);
  // The pixel completes once the gathered count reaches or passes the size.
  assign pix_done  = ({1'b0, pos_eff} + 3'd1) >= pix_size;
  assign produce   = in_acc && !is_header && pix_done;
  assign count     = (rle_en_r && run_eff) ? left_eff : 8'd1;
  assign conv      = trle_pkg::convert_pixel(store_ins, src_bytes_r, out_comp_r);

  always_comb begin
    res.format_error = conv.format_error;
    res.repeat_count = count;
    res.chan3        = conv.chan3;
    res.chan2        = conv.chan2;
    res.chan1        = conv.chan1;
    res.chan0        = conv.chan0;
  end

  always_comb begin
    packet_left_nxt = left_eff;
    packet_run_nxt  = run_eff;
    byte_pos_nxt    = pos_eff;
    pix_store_nxt   = store_ins;
    if (is_header) begin
      // Header: count is the low seven bits plus one, top bit selects a run.
      packet_left_nxt = {1'b0, in_tdata[6:0]} + 8'd1;
      packet_run_nxt  = in_tdata[7];
      byte_pos_nxt    = 2'd0;
      pix_store_nxt   = store_eff;
    end else if (!pix_done) begin
      byte_pos_nxt = pos_eff + 2'd1;
    end else begin
      byte_pos_nxt = 2'd0;
      if (rle_en_r) begin
        packet_left_nxt = run_eff ? 8'd0 : left_eff - 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      packet_left_r <= 8'd0;
      packet_run_r  <= 1'b0;
      byte_pos_r    <= 2'd0;
      pix_store_r   <= 32'd0;
    end else if (in_acc) begin
      packet_left_r <= packet_left_nxt;
      packet_run_r  <= packet_run_nxt;
      byte_pos_r    <= byte_pos_nxt;
      pix_store_r   <= pix_store_nxt;
    end
  end

  // Output stage control. The skid register only fills while the result register is
  // held, and in_tready is low whenever it is full, so no result can be dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || out_pop) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r  <= produce;
      end
    end else if (produce) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || out_pop) begin
      out_res_r <= skid_v_r ? skid_res_r : res;
    end
    if (produce && out_v_r && !out_pop) begin
      skid_res_r <= res;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {out_res_r.repeat_count, out_res_r.chan3, out_res_r.chan2,
                       out_res_r.chan1, out_res_r.chan0};
  assign out_tuser  = out_res_r.format_error;

  `TRLE_ASSERT_NOW(a_skid_behind_out, clk, rst_n, skid_v_r, out_v_r)
  `TRLE_ASSERT_NEXT(a_skid_holds, clk, rst_n, skid_v_r && !out_tready, skid_v_r)
  `TRLE_ASSERT_NOW(a_left_range, clk, rst_n, 1'b1, packet_left_r <= 8'd128)
  `TRLE_ASSERT_NOW(a_count_nonzero, clk, rst_n, out_v_r, out_res_r.repeat_count != 8'd0)
  `TRLE_ASSERT_NOW(a_error_blanks, clk, rst_n, out_v_r && out_res_r.format_error,
                   out_tdata[31:0] == 32'd0)

endmodule
`default_nettype wire

// File: verif/tga_rle_pixel_decoder_unit_tb.sv
// Self-checking testbench of the Targa run-length pixel decoder, with its scoreboard class.
`timescale 1ns / 1ps

// The testbench drives the decoder's byte stream and its configuration port and checks
// every output beat against a prediction made inside the testbench. A small scoreboard
// class keeps its own copy of the registers and of the packet and pixel state. It is fed
// every accepted input beat and every accepted register write, and it queues one expected
// pixel for each byte that completes a stored pixel. Each output beat is compared, field
// by field, with the oldest queued pixel.
//
// Stimulus runs in phases. Registers are only written between phases, once every queued
// pixel has arrived and a few more cycles have passed. A short directed part covers the
// extreme runs, a literal pixel, a new image started in the middle of a pixel, a size
// change while a pixel is half gathered, raw mode with a packet left open, the 5-5-5
// conversion and out-of-range register values. One phase stops the receiver for a long
// stretch while the sender keeps offering bytes, so the output stage fills up and the
// input stalls. The random part is mostly well-formed packets with random content, plus
// some noise bytes and stray image starts.
module tga_rle_pixel_decoder_unit_tb;
  import trle_pkg::*;

  // The register index that the decoder does not use; writes to it must change nothing.
  localparam logic [1:0] CFG_SPARE     = 2'd3;
  localparam int         RESET_CYCLES  = 6;
  localparam int         SETTLE_CYCLES = 4;
  localparam int         HOLD_CYCLES   = 300;
  localparam int         IDLE_LIMIT    = 3000;
  localparam int         RANDOM_ITEMS  = 700;

  // Keeps the predicted decoder state and the queue of pixels still to come out.
  class pixel_scoreboard;
    logic [2:0]  src_bytes;
    logic [2:0]  out_comp;
    logic        rle_on;
    logic [7:0]  pkt_left;
    logic        pkt_run;
    logic [1:0]  byte_pos;
    logic [31:0] pix_store;
    res_t        pixels_due[$];
    int          errors;

    function new();
      src_bytes = SZ_3;
      out_comp  = SZ_3;
      rle_on    = 1'b1;
      pkt_left  = '0;
      pkt_run   = 1'b0;
      byte_pos  = '0;
      pix_store = '0;
      errors    = 0;
    endfunction

    function void note_config(logic [1:0] idx, logic [2:0] val);
      case (idx)
        CFG_SOURCE_BYTES:   src_bytes = val;
        CFG_OUT_COMPONENTS: out_comp  = val;
        CFG_RLE_ENABLE:     rle_on    = val[0];
        default: ;
      endcase
    endfunction

    // Out-of-range sizes still gather: below one counts as one, above four as four.
    function int gather_size();
      if (src_bytes < SZ_1) return 1;
      if (src_bytes > SZ_4) return 4;
      return int'(src_bytes);
    endfunction

    function res_t convert(int count);
      res_t       r;
      logic [7:0] b0;
      logic [7:0] b1;
      logic [7:0] b2;
      logic [7:0] b3;
      r  = '0;
      b0 = pix_store[7:0];
      b1 = pix_store[15:8];
      b2 = pix_store[23:16];
      b3 = pix_store[31:24];
      r.repeat_count = count[7:0];
      case ({src_bytes, out_comp})
        {SZ_2, SZ_3}, {SZ_2, SZ_4}: begin
          r.chan0 = (b1 & 8'h7c) << 1;
          r.chan1 = ((b1 & 8'h03) << 6) | ((b0 & 8'he0) >> 2);
          r.chan2 = (b0 & 8'h1f) << 3;
          if (out_comp == SZ_4) r.chan3 = b1[7] ? 8'hff : 8'h00;
        end
        {SZ_3, SZ_3}, {SZ_4, SZ_3}: begin
          r.chan0 = b2;
          r.chan1 = b1;
          r.chan2 = b0;
        end
        {SZ_4, SZ_4}: begin
          r.chan0 = b2;
          r.chan1 = b1;
          r.chan2 = b0;
          r.chan3 = b3;
        end
        {SZ_1, SZ_1}, {SZ_2, SZ_1}: begin
          r.chan0 = b0;
        end
        {SZ_2, SZ_2}: begin
          r.chan0 = b0;
          r.chan1 = b1;
        end
        default: begin
          r.format_error = 1'b1;
        end
      endcase
      return r;
    endfunction

    function void note_input(logic [7:0] b, logic start);
      int pos;
      int count;
      if (start) begin
        pkt_left  = '0;
        pkt_run   = 1'b0;
        byte_pos  = '0;
        pix_store = '0;
      end
      // With no packet open, the byte is a header and yields nothing.
      if (rle_on && pkt_left == 8'd0) begin
        pkt_left = {1'b0, b[6:0]} + 8'd1;
        pkt_run  = b[7];
        byte_pos = '0;
        return;
      end
      pos = int'(byte_pos);
      pix_store[8*pos +: 8] = b;
      // A pixel completes once the byte count reaches or passes the current size.
      if (pos + 1 < gather_size()) begin
        byte_pos = byte_pos + 2'd1;
        return;
      end
      byte_pos = '0;
      count    = 1;
      if (rle_on) begin
        if (pkt_run) begin
          count    = int'(pkt_left);
          pkt_left = '0;
        end else begin
          pkt_left = pkt_left - 8'd1;
        end
      end
      pixels_due.push_back(convert(count));
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
    endfunction

    function void check_result(logic [39:0] td, logic fe);
      res_t want;
      if (pixels_due.size() == 0) begin
        errors++;
        $display("%0t: output beat with nothing expected, expected none, actual %h/%b",
                 $time, td, fe);
        return;
      end
      want = pixels_due.pop_front();
      compare_field("chan0", want.chan0, td[7:0]);
      compare_field("chan1", want.chan1, td[15:8]);
      compare_field("chan2", want.chan2, td[23:16]);
      compare_field("chan3", want.chan3, td[31:24]);
      compare_field("repeat_count", want.repeat_count, td[39:32]);
      compare_field("format_error", {7'd0, want.format_error}, {7'd0, fe});
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic [0:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;
  logic [0:0]  out_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [2:0]  cfg_data;

  pixel_scoreboard sb;
  int              items_sent;
  int              idle_cycles;
  int              rx_hold;
  bit              tx_burst;

  tga_rle_pixel_decoder_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // All handshakes are sampled at the rising edge, before any driver update of that edge
  // takes effect, so the order of processes within the step does not matter.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser[0]);
      if (in_tvalid && in_tready) sb.note_input(in_tdata, in_tuser[0]);
      if (cfg_valid && cfg_ready) sb.note_config(cfg_index, cfg_data);
    end
  end

  // Ends the run when no beat of any kind has moved for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tga_rle_pixel_decoder_unit_tb: done, errors");
        $finish;
      end
    end
  end

  // Receiver: ready most of the time, with short and occasional long stalls, calm
  // stretches without any stall, and a long hold-off whenever rx_hold is set.
  initial begin
    int stall_left;
    int calm_left;
    out_tready = 1'b0;
    stall_left = 0;
    calm_left  = 0;
    @(posedge clk);
    forever begin
      if (rx_hold > 0) begin
        stall_left = rx_hold;
        rx_hold    = 0;
      end
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
        if (calm_left > 0) begin
          calm_left--;
        end else if ($urandom_range(0, 99) < 2) begin
          calm_left = $urandom_range(20, 150);
        end else if ($urandom_range(0, 99) < 30) begin
          stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 50)
                                                   : $urandom_range(1, 3);
        end
      end
      @(posedge clk);
    end
  end

  function automatic int pick_gap();
    int r;
    if (tx_burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [7:0] rand_byte();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hff;
    return 8'($urandom_range(0, 255));
  endfunction

  // Mostly legal sizes and layouts, sometimes the out-of-range values 0, 5, 6 and 7.
  function automatic logic [2:0] pick_reg_value();
    int r;
    if ($urandom_range(0, 9) < 8) return 3'($urandom_range(1, 4));
    r = $urandom_range(0, 3);
    return (r == 0) ? 3'd0 : 3'(4 + r);
  endfunction

  // Offers one byte beat, holds it until it is taken, then idles for a random gap.
  task automatic send_byte(input logic [7:0] b, input logic start);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= start;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [2:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Stops the sender and waits until every predicted pixel has come out, then waits
  // SETTLE_CYCLES more so that a trailing header byte is surely absorbed.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pixels_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Sends the bytes of whole pixels; only the first byte may carry a start flag.
  task automatic send_pixels(input int pixels, input int size, inout logic start);
    repeat (pixels * size) begin
      send_byte(rand_byte(), start);
      start = 1'b0;
    end
  endtask

  task automatic random_phase();
    logic [2:0] s;
    logic [2:0] d;
    logic       rle;
    logic       start;
    logic [7:0] hdr;
    int         size;
    int         packets;
    int         n;
    wait_idle();
    s   = pick_reg_value();
    d   = pick_reg_value();
    rle = ($urandom_range(0, 3) != 0);
    write_reg(CFG_SOURCE_BYTES, s);
    write_reg(CFG_OUT_COMPONENTS, d);
    write_reg(CFG_RLE_ENABLE, {2'b00, rle});
    if ($urandom_range(0, 9) == 0) write_reg(CFG_SPARE, 3'($urandom_range(0, 7)));
    size     = (s < SZ_1) ? 1 : (s > SZ_4) ? 4 : int'(s);
    tx_burst = ($urandom_range(0, 4) == 0);
    start    = 1'($urandom_range(0, 1));
    packets  = $urandom_range(2, 10);
    repeat (packets) begin
      if ($urandom_range(0, 99) < 85) begin
        if (rle) begin
          // Well-formed packet: counts are mostly small, now and then up to 128.
          hdr[7]   = 1'($urandom_range(0, 1));
          hdr[6:0] = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(0, 127))
                                                 : 7'($urandom_range(0, 7));
          if ($urandom_range(0, 19) == 0) hdr[6:0] = 7'h7f;
          send_byte(hdr, start);
          start = 1'b0;
          n = hdr[7] ? 1 : int'(hdr[6:0]) + 1;
          send_pixels(n, size, start);
        end else begin
          send_pixels($urandom_range(1, 8), size, start);
        end
      end else begin
        // Noise: a few loose bytes, some of them starting a new image.
        repeat ($urandom_range(1, 5)) begin
          send_byte(rand_byte(), ($urandom_range(0, 6) == 0) || start);
          start = 1'b0;
        end
      end
    end
    tx_burst = 1'b0;
  endtask

  initial begin
    int random_base;
    sb         = new();
    items_sent = 0;
    rx_hold    = 0;
    tx_burst   = 1'b0;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = '0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Reset layout is BGR to RGB with packets. A run of one black pixel.
    send_byte(8'h80, 1'b0);
    repeat (3) send_byte(8'h00, 1'b0);
    // The longest run, all white.
    send_byte(8'hff, 1'b0);
    repeat (3) send_byte(8'hff, 1'b0);
    // One literal pixel with distinct bytes, to see the byte swap.
    send_byte(8'h00, 1'b0);
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b0);
    send_byte(8'h56, 1'b0);
    // A new image starts in the middle of a pixel; the flagged byte is a header again.
    send_byte(8'h00, 1'b0);
    send_byte(8'h11, 1'b0);
    send_byte(8'h80, 1'b1);
    send_byte(8'h01, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'h03, 1'b0);
    // Literal of two, left after two bytes of its first pixel.
    send_byte(8'h01, 1'b0);
    send_byte(8'haa, 1'b0);
    send_byte(8'hbb, 1'b0);

    // Shrinking the size mid pixel completes it on the next byte; 1 to RGB is unsupported.
    wait_idle();
    write_reg(CFG_SOURCE_BYTES, SZ_1);
    send_byte(8'hcc, 1'b0);

    // Raw 5-5-5 to RGBA with the literal packet still open, alpha bit set then clear.
    wait_idle();
    write_reg(CFG_SOURCE_BYTES, SZ_2);
    write_reg(CFG_OUT_COMPONENTS, SZ_4);
    write_reg(CFG_RLE_ENABLE, 3'd0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h7f, 1'b0);

    // Size zero and layout seven: the open literal finishes, then a run of two.
    wait_idle();
    write_reg(CFG_SOURCE_BYTES, 3'd0);
    write_reg(CFG_OUT_COMPONENTS, 3'd7);
    write_reg(CFG_RLE_ENABLE, 3'd1);
    send_byte(8'h81, 1'b0);
    send_byte(8'h81, 1'b0);
    send_byte(8'h9a, 1'b0);

    // Size seven gathers four bytes; layout zero is unsupported.
    wait_idle();
    write_reg(CFG_SOURCE_BYTES, 3'd7);
    write_reg(CFG_OUT_COMPONENTS, 3'd0);
    write_reg(CFG_SPARE, 3'd7);
    send_byte(8'h00, 1'b0);
    send_byte(8'h5a, 1'b0);
    send_byte(8'ha5, 1'b0);
    send_byte(8'h0f, 1'b0);
    send_byte(8'hf0, 1'b0);

    // Back pressure: raw grey gives a pixel per byte while the receiver holds off, so the
    // output stage fills and the input stalls. The sender then waits for every result.
    wait_idle();
    write_reg(CFG_SOURCE_BYTES, SZ_1);
    write_reg(CFG_OUT_COMPONENTS, SZ_1);
    write_reg(CFG_RLE_ENABLE, 3'd0);
    tx_burst = 1'b1;
    rx_hold  = HOLD_CYCLES;
    repeat (40) send_byte(rand_byte(), 1'b0);
    tx_burst = 1'b0;

    random_base = items_sent;
    while (items_sent - random_base < RANDOM_ITEMS) random_phase();

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pixels_due.size() == 0) begin
      $display("tga_rle_pixel_decoder_unit_tb: done, clean");
    end else begin
      $display("tga_rle_pixel_decoder_unit_tb: done, errors");
    end
    $finish;
  end

endmodule
